[hw/rtl/egp_pkg.sv]
// Shared types, constants and the colour map for the elevation grid pseudocolor block.
// No dependencies.
package egp_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int ELEV_BITS_DEF  = 16;
    localparam int DIM_BITS       = 9;
    localparam int COORD_BITS     = 8;
    localparam int IDX_BITS       = 8;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_COLOR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_WAIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic load;
        logic mem_rd;
        logic capture;
        logic div_start;
        logic div_step;
        logic done;
    } egp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic needs_mem;
        logic needs_div;
        logic div_last;
    } egp_sts_t;

    // Blue-green-red map, packed as {r, g, b}.
    localparam logic [23:0] COLOR_MAP [256] = '{
        24'h000000, 24'h0004ff, 24'h0007ff, 24'h000bff, 24'h0010ff, 24'h0013ff, 24'h0018ff,
        24'h001cff, 24'h001fff, 24'h0024ff, 24'h0027ff, 24'h002bff, 24'h0030ff, 24'h0033ff,
        24'h0038ff, 24'h003bff, 24'h003fff, 24'h0044ff, 24'h0047ff, 24'h004cff, 24'h0050ff,
        24'h0053ff, 24'h0058ff, 24'h005bff, 24'h005fff, 24'h0064ff, 24'h0067ff, 24'h006cff,
        24'h0070ff, 24'h0073ff, 24'h0078ff, 24'h007bff, 24'h007fff, 24'h0084ff, 24'h0087ff,
        24'h008cff, 24'h0090ff, 24'h0093ff, 24'h0098ff, 24'h009bff, 24'h009fff, 24'h00a4ff,
        24'h00a7ff, 24'h00acff, 24'h00afff, 24'h00b3ff, 24'h00b8ff, 24'h00bbff, 24'h00c0ff,
        24'h00c4ff, 24'h00c7ff, 24'h00ccff, 24'h00cfff, 24'h00d3ff, 24'h00d8ff, 24'h00dbff,
        24'h00e0ff, 24'h00e4ff, 24'h00e7ff, 24'h00ecff, 24'h00efff, 24'h00f3ff, 24'h00f8ff,
        24'h00fbff, 24'h00fffd, 24'h00fff9, 24'h00fff6, 24'h00fff1, 24'h00ffee, 24'h00ffea,
        24'h00ffe5, 24'h00ffe2, 24'h00ffdd, 24'h00ffda, 24'h00ffd6, 24'h00ffd1, 24'h00ffce,
        24'h00ffc9, 24'h00ffc5, 24'h00ffc2, 24'h00ffbd, 24'h00ffba, 24'h00ffb6, 24'h00ffb1,
        24'h00ffae, 24'h00ffa9, 24'h00ffa5, 24'h00ffa2, 24'h00ff9d, 24'h00ff9a, 24'h00ff96,
        24'h00ff91, 24'h00ff8e, 24'h00ff89, 24'h00ff85, 24'h00ff82, 24'h00ff7d, 24'h00ff7a,
        24'h00ff76, 24'h00ff71, 24'h00ff6e, 24'h00ff69, 24'h00ff66, 24'h00ff62, 24'h00ff5d,
        24'h00ff5a, 24'h00ff55, 24'h00ff51, 24'h00ff4e, 24'h00ff49, 24'h00ff46, 24'h00ff42,
        24'h00ff3d, 24'h00ff3a, 24'h00ff35, 24'h00ff31, 24'h00ff2e, 24'h00ff29, 24'h00ff26,
        24'h00ff22, 24'h00ff1d, 24'h00ff1a, 24'h00ff15, 24'h00ff11, 24'h00ff0e, 24'h00ff09,
        24'h00ff06, 24'h00ff02, 24'h02ff00, 24'h05ff00, 24'h0aff00, 24'h0eff00, 24'h11ff00,
        24'h16ff00, 24'h19ff00, 24'h1eff00, 24'h22ff00, 24'h25ff00, 24'h2aff00, 24'h2dff00,
        24'h31ff00, 24'h36ff00, 24'h39ff00, 24'h3eff00, 24'h42ff00, 24'h45ff00, 24'h4aff00,
        24'h4dff00, 24'h51ff00, 24'h56ff00, 24'h59ff00, 24'h5eff00, 24'h62ff00, 24'h65ff00,
        24'h6aff00, 24'h6dff00, 24'h71ff00, 24'h76ff00, 24'h79ff00, 24'h7eff00, 24'h82ff00,
        24'h85ff00, 24'h8aff00, 24'h8dff00, 24'h92ff00, 24'h96ff00, 24'h99ff00, 24'h9eff00,
        24'ha1ff00, 24'ha5ff00, 24'haaff00, 24'hadff00, 24'hb2ff00, 24'hb6ff00, 24'hb9ff00,
        24'hbeff00, 24'hc1ff00, 24'hc5ff00, 24'hcaff00, 24'hcdff00, 24'hd2ff00, 24'hd6ff00,
        24'hd9ff00, 24'hdeff00, 24'he1ff00, 24'he5ff00, 24'heaff00, 24'hedff00, 24'hf2ff00,
        24'hf6ff00, 24'hf9ff00, 24'hfeff00, 24'hfffc00, 24'hfff700, 24'hfff300, 24'hfff000,
        24'hffeb00, 24'hffe800, 24'hffe400, 24'hffdf00, 24'hffdc00, 24'hffd700, 24'hffd300,
        24'hffd000, 24'hffcb00, 24'hffc800, 24'hffc400, 24'hffbf00, 24'hffbc00, 24'hffb700,
        24'hffb300, 24'hffb000, 24'hffab00, 24'hffa800, 24'hffa400, 24'hff9f00, 24'hff9c00,
        24'hff9700, 24'hff9300, 24'hff9000, 24'hff8b00, 24'hff8800, 24'hff8400, 24'hff7f00,
        24'hff7c00, 24'hff7700, 24'hff7400, 24'hff7000, 24'hff6b00, 24'hff6800, 24'hff6300,
        24'hff5f00, 24'hff5c00, 24'hff5700, 24'hff5400, 24'hff5000, 24'hff4b00, 24'hff4800,
        24'hff4300, 24'hff3f00, 24'hff3c00, 24'hff3700, 24'hff3400, 24'hff3000, 24'hff2b00,
        24'hff2800, 24'hff2300, 24'hff1f00, 24'hff1c00, 24'hff1700, 24'hff1400, 24'hff1000,
        24'hff0b00, 24'hff0800, 24'hff0300, 24'hff0000
    };

    function automatic logic [23:0] color_lut(input logic [7:0] i);
        return COLOR_MAP[i];
    endfunction

endpackage

[hw/rtl/egp_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module egp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[hw/rtl/egp_ctrl.sv]
// Controller state machine: clearing pass, item sequencing, divider pacing.
// Depends on egp_pkg.
module egp_ctrl
    import egp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_fire,
    input  egp_sts_t sts,
    output egp_cmd_t cmd,
    output logic     in_ready,
    output logic     out_valid
);
    state_t state_reg, state_next;
    logic   started_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (started_reg && sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:  if (in_fire) state_next = ST_READ;
            ST_READ:  state_next = sts.needs_mem ? ST_WAIT : ST_OUT;
            ST_WAIT:  state_next = sts.needs_div ? ST_DIV : ST_OUT;
            ST_DIV:   if (sts.div_last) state_next = ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_start = !started_reg;
                cmd.clr_step  = started_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_READ:  cmd.mem_rd = 1'b1;
            ST_WAIT:
            begin
                cmd.capture   = 1'b1;
                cmd.div_start = sts.needs_div;
            end
            ST_DIV:   cmd.div_step = 1'b1;
            ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.done  = out_fire;
            end
            default: ;
        endcase
    end
endmodule

[hw/rtl/egp_dp.sv]
// Datapath: grid memory, min/max tracking, restoring divider, colour lookup.
// Depends on egp_pkg and egp_ram.
module egp_dp
    import egp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int ELEV_BITS  = ELEV_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  egp_cmd_t              cmd,
    output egp_sts_t              sts,
    input  logic [1:0]            mode,
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    input  logic signed [15:0]    write_value,
    input  logic [DIM_BITS-1:0]   grid_width,
    input  logic [DIM_BITS-1:0]   grid_height,
    output logic                  status,
    output logic signed [15:0]    elevation_out,
    output logic [7:0]            red_level,
    output logic [7:0]            green_level,
    output logic [7:0]            blue_level
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int SB    = ELEV_BITS + 1;          // span and offset width
    localparam int NB    = SB + IDX_BITS;          // dividend width
    localparam int CB    = $clog2(NB + 1);

    logic [AW-1:0]        clr_addr_reg;
    logic [1:0]           mode_reg;
    logic                 inside_reg;
    logic [AW-1:0]        addr_reg;
    logic [ELEV_BITS-1:0] wv_reg;
    logic signed [ELEV_BITS-1:0] min_reg, max_reg, elev_reg;
    logic [NB-1:0]        quo_reg;
    logic [SB-1:0]        rem_reg, span_reg;
    logic [CB-1:0]        cnt_reg;
    logic [1:0]           idx_sel_reg;   // 0 divide, 1 force 0, 2 force 255

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          in_grid;
    logic [AW-1:0] addr;
    logic          we;
    logic [AW-1:0] ram_addr;
    logic [ELEV_BITS-1:0] ram_wdata, ram_rdata;
    logic signed [ELEV_BITS-1:0] wv_s, rd_s;
    logic [SB-1:0] rem_sh, rem_sub;
    logic [7:0]    idx;
    logic [23:0]   rgb;

    always_comb
    begin
        w_eff = (32'(grid_width) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(grid_width);
        h_eff = (32'(grid_height) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(grid_height);
        in_grid = (32'(x_coord) < 32'(w_eff)) && (32'(y_coord) < 32'(h_eff));
        addr = AW'(32'(y_coord) * 32'(w_eff) + 32'(x_coord));
    end

    assign wv_s = signed'(ELEV_BITS'(write_value));
    assign rd_s = signed'(ram_rdata);

    always_comb
    begin
        we        = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = wv_reg;
        if (cmd.clr_step)
        begin
            we        = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.mem_rd && mode_reg == MODE_WRITE && inside_reg)
        begin
            we = 1'b1;
        end
    end

    egp_ram #(.WIDTH(ELEV_BITS), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign sts.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.needs_mem = inside_reg && (mode_reg == MODE_READ || mode_reg == MODE_COLOR);
    assign sts.needs_div = (mode_reg == MODE_COLOR) && (max_reg > min_reg)
                           && (rd_s < max_reg) && (rd_s > min_reg);
    assign sts.div_last  = (cnt_reg == CB'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.mem_rd && mode_reg == MODE_WRITE && inside_reg)
            begin
                if (signed'(wv_reg) < min_reg) min_reg <= signed'(wv_reg);
                if (signed'(wv_reg) > max_reg) max_reg <= signed'(wv_reg);
            end
            if (cmd.div_start)
            begin
                cnt_reg <= CB'(NB);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CB'(1);
            end
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {rem_reg[SB-2:0], quo_reg[NB-1]};
    assign rem_sub = rem_sh - span_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            inside_reg <= in_grid;
            addr_reg   <= in_grid ? addr : '0;
            wv_reg     <= wv_s;
        end
        if (cmd.capture)
        begin
            elev_reg <= rd_s;
            if (max_reg <= min_reg || rd_s >= max_reg)
                idx_sel_reg <= 2'd2;
            else if (rd_s <= min_reg)
                idx_sel_reg <= 2'd1;
            else
                idx_sel_reg <= 2'd0;
        end
        if (cmd.div_start)
        begin
            // offset*255 = (offset<<8) - offset
            quo_reg  <= ({IDX_BITS'(0), SB'(rd_s - min_reg)} << IDX_BITS)
                        - {IDX_BITS'(0), SB'(rd_s - min_reg)};
            rem_reg  <= '0;
            span_reg <= SB'(max_reg - min_reg);
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= span_reg)
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[NB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        unique case (idx_sel_reg)
            2'd0:    idx = (quo_reg > NB'(255)) ? 8'd255 : quo_reg[7:0];
            2'd1:    idx = 8'd0;
            default: idx = 8'd255;
        endcase
        rgb = color_lut(idx);
    end

    always_comb
    begin
        status        = 1'b0;
        elevation_out = '0;
        red_level     = '0;
        green_level   = '0;
        blue_level    = '0;
        if (mode_reg != MODE_NOP)
        begin
            if (!inside_reg)
            begin
                status        = 1'b1;
                elevation_out = '1;
            end
            else if (mode_reg != MODE_WRITE)
            begin
                elevation_out = 16'(elev_reg);
                if (mode_reg == MODE_COLOR)
                begin
                    red_level   = rgb[23:16];
                    green_level = rgb[15:8];
                    blue_level  = rgb[7:0];
                end
            end
        end
    end
endmodule

[hw/rtl/elevation_grid_pseudocolor.sv]
// Top level of the elevation grid pseudocolor block: ports, config registers.
// Depends on egp_pkg, egp_ctrl, egp_dp.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata {write_value, y_coord, x_coord, mode} 34b in 40b
//  m_axis   | out       | tdata {blue, green, red, elevation_out, status} 41b in 48b
//  cfg      | in        | cfg_index (0 width, 1 height), cfg_data 9b
//
// A write, a nop or an item outside the grid passes the read and output states, a
// read adds a wait state for the memory read, and a colour read whose value lies
// strictly between min and max also runs a restoring divider that yields one of 25
// quotient bits a cycle. After reset a clearing pass writes zero to all
// MAX_WIDTH*MAX_HEIGHT cells, one per cycle after a start step; no item is taken during it.
// The result is held until m_axis_tready; one item at a time is in flight.
module elevation_grid_pseudocolor
    import egp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int ELEV_BITS  = ELEV_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // mode[1:0] x[9:2] y[17:10] write_value[33:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status[0] elev[16:1] r[24:17] g[32:25] b[40:33]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    logic [DIM_BITS-1:0] width_reg, height_reg;
    egp_cmd_t cmd;
    egp_sts_t sts;
    logic in_fire, out_fire;
    logic status;
    logic signed [15:0] elev;
    logic [7:0] r, g, b;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(256);
            height_reg <= DIM_BITS'(256);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    egp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid)
    );

    egp_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ELEV_BITS  (ELEV_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (s_axis_tdata[1:0]),
        .x_coord       (s_axis_tdata[9:2]),
        .y_coord       (s_axis_tdata[17:10]),
        .write_value   (s_axis_tdata[33:18]),
        .grid_width    (width_reg),
        .grid_height   (height_reg),
        .status        (status),
        .elevation_out (elev),
        .red_level     (r),
        .green_level   (g),
        .blue_level    (b)
    );

    assign m_axis_tdata = {7'd0, b, g, r, elev, status};

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

[test/tb_elevation_grid_pseudocolor.sv]
// Self-checking testbench for elevation_grid_pseudocolor: random and directed grid items,
// predicted in a local model of the grid, min/max tracking and colour map.
// Depends on egp_pkg and the elevation_grid_pseudocolor RTL.
module tb_elevation_grid_pseudocolor;
    import egp_pkg::*;

    typedef struct packed {
        logic signed [15:0] value;
        logic [7:0]         y;
        logic [7:0]         x;
        mode_t              mode;
    } grid_op_t;

    typedef struct packed {
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic signed [15:0] elev;
        logic               status;
    } pixel_t;

    localparam int IDLE_LIMIT = 200000;

    // Blue-green-red map, {r, g, b} per entry.
    localparam logic [23:0] CMAP [256] = '{
        24'h000000, 24'h0004ff, 24'h0007ff, 24'h000bff, 24'h0010ff, 24'h0013ff, 24'h0018ff,
        24'h001cff, 24'h001fff, 24'h0024ff, 24'h0027ff, 24'h002bff, 24'h0030ff, 24'h0033ff,
        24'h0038ff, 24'h003bff, 24'h003fff, 24'h0044ff, 24'h0047ff, 24'h004cff, 24'h0050ff,
        24'h0053ff, 24'h0058ff, 24'h005bff, 24'h005fff, 24'h0064ff, 24'h0067ff, 24'h006cff,
        24'h0070ff, 24'h0073ff, 24'h0078ff, 24'h007bff, 24'h007fff, 24'h0084ff, 24'h0087ff,
        24'h008cff, 24'h0090ff, 24'h0093ff, 24'h0098ff, 24'h009bff, 24'h009fff, 24'h00a4ff,
        24'h00a7ff, 24'h00acff, 24'h00afff, 24'h00b3ff, 24'h00b8ff, 24'h00bbff, 24'h00c0ff,
        24'h00c4ff, 24'h00c7ff, 24'h00ccff, 24'h00cfff, 24'h00d3ff, 24'h00d8ff, 24'h00dbff,
        24'h00e0ff, 24'h00e4ff, 24'h00e7ff, 24'h00ecff, 24'h00efff, 24'h00f3ff, 24'h00f8ff,
        24'h00fbff, 24'h00fffd, 24'h00fff9, 24'h00fff6, 24'h00fff1, 24'h00ffee, 24'h00ffea,
        24'h00ffe5, 24'h00ffe2, 24'h00ffdd, 24'h00ffda, 24'h00ffd6, 24'h00ffd1, 24'h00ffce,
        24'h00ffc9, 24'h00ffc5, 24'h00ffc2, 24'h00ffbd, 24'h00ffba, 24'h00ffb6, 24'h00ffb1,
        24'h00ffae, 24'h00ffa9, 24'h00ffa5, 24'h00ffa2, 24'h00ff9d, 24'h00ff9a, 24'h00ff96,
        24'h00ff91, 24'h00ff8e, 24'h00ff89, 24'h00ff85, 24'h00ff82, 24'h00ff7d, 24'h00ff7a,
        24'h00ff76, 24'h00ff71, 24'h00ff6e, 24'h00ff69, 24'h00ff66, 24'h00ff62, 24'h00ff5d,
        24'h00ff5a, 24'h00ff55, 24'h00ff51, 24'h00ff4e, 24'h00ff49, 24'h00ff46, 24'h00ff42,
        24'h00ff3d, 24'h00ff3a, 24'h00ff35, 24'h00ff31, 24'h00ff2e, 24'h00ff29, 24'h00ff26,
        24'h00ff22, 24'h00ff1d, 24'h00ff1a, 24'h00ff15, 24'h00ff11, 24'h00ff0e, 24'h00ff09,
        24'h00ff06, 24'h00ff02, 24'h02ff00, 24'h05ff00, 24'h0aff00, 24'h0eff00, 24'h11ff00,
        24'h16ff00, 24'h19ff00, 24'h1eff00, 24'h22ff00, 24'h25ff00, 24'h2aff00, 24'h2dff00,
        24'h31ff00, 24'h36ff00, 24'h39ff00, 24'h3eff00, 24'h42ff00, 24'h45ff00, 24'h4aff00,
        24'h4dff00, 24'h51ff00, 24'h56ff00, 24'h59ff00, 24'h5eff00, 24'h62ff00, 24'h65ff00,
        24'h6aff00, 24'h6dff00, 24'h71ff00, 24'h76ff00, 24'h79ff00, 24'h7eff00, 24'h82ff00,
        24'h85ff00, 24'h8aff00, 24'h8dff00, 24'h92ff00, 24'h96ff00, 24'h99ff00, 24'h9eff00,
        24'ha1ff00, 24'ha5ff00, 24'haaff00, 24'hadff00, 24'hb2ff00, 24'hb6ff00, 24'hb9ff00,
        24'hbeff00, 24'hc1ff00, 24'hc5ff00, 24'hcaff00, 24'hcdff00, 24'hd2ff00, 24'hd6ff00,
        24'hd9ff00, 24'hdeff00, 24'he1ff00, 24'he5ff00, 24'heaff00, 24'hedff00, 24'hf2ff00,
        24'hf6ff00, 24'hf9ff00, 24'hfeff00, 24'hfffc00, 24'hfff700, 24'hfff300, 24'hfff000,
        24'hffeb00, 24'hffe800, 24'hffe400, 24'hffdf00, 24'hffdc00, 24'hffd700, 24'hffd300,
        24'hffd000, 24'hffcb00, 24'hffc800, 24'hffc400, 24'hffbf00, 24'hffbc00, 24'hffb700,
        24'hffb300, 24'hffb000, 24'hffab00, 24'hffa800, 24'hffa400, 24'hff9f00, 24'hff9c00,
        24'hff9700, 24'hff9300, 24'hff9000, 24'hff8b00, 24'hff8800, 24'hff8400, 24'hff7f00,
        24'hff7c00, 24'hff7700, 24'hff7400, 24'hff7000, 24'hff6b00, 24'hff6800, 24'hff6300,
        24'hff5f00, 24'hff5c00, 24'hff5700, 24'hff5400, 24'hff5000, 24'hff4b00, 24'hff4800,
        24'hff4300, 24'hff3f00, 24'hff3c00, 24'hff3700, 24'hff3400, 24'hff3000, 24'hff2b00,
        24'hff2800, 24'hff2300, 24'hff1f00, 24'hff1c00, 24'hff1700, 24'hff1400, 24'hff1000,
        24'hff0b00, 24'hff0800, 24'hff0300, 24'hff0000
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_WIDTH;
    logic [8:0]  cfg_data = '0;

    // model of the block
    logic signed [15:0] cells [65536];
    logic signed [15:0] elev_lo;
    logic signed [15:0] elev_hi;
    logic [8:0]         cols_reg;
    logic [8:0]         rows_reg;

    grid_op_t pending_ops [$];
    pixel_t   expected_pixels [$];
    logic     hold_ops = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;

    elevation_grid_pseudocolor uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pixel_t apply_op(grid_op_t op);
        pixel_t     px;
        int         cols;
        int         rows;
        int         addr;
        int         span;
        int         offs;
        int         idx;
        logic signed [15:0] e;
        cols = (cols_reg > 256) ? 256 : cols_reg;
        rows = (rows_reg > 256) ? 256 : rows_reg;
        px = '0;
        if (op.mode == MODE_NOP)
            return px;
        if (op.x >= cols || op.y >= rows)
        begin
            px.status = 1'b1;
            px.elev = -16'sd1;
            return px;
        end
        addr = op.y * cols + op.x;
        if (op.mode == MODE_WRITE)
        begin
            cells[addr] = op.value;
            if (op.value < elev_lo) elev_lo = op.value;
            if (op.value > elev_hi) elev_hi = op.value;
            return px;
        end
        e = cells[addr];
        px.elev = e;
        if (op.mode == MODE_COLOR)
        begin
            if (elev_hi <= elev_lo || e >= elev_hi)
                idx = 255;
            else if (e <= elev_lo)
                idx = 0;
            else
            begin
                span = int'(elev_hi) - int'(elev_lo);
                offs = int'(e) - int'(elev_lo);
                idx = (offs * 255) / span;
                if (idx > 255) idx = 255;
            end
            {px.red, px.green, px.blue} = CMAP[idx];
        end
        return px;
    endfunction

    function automatic grid_op_t random_op(int cols, int rows);
        grid_op_t op;
        int       pick;
        int       ec;
        int       er;
        ec = (cols > 256) ? 256 : cols;
        er = (rows > 256) ? 256 : rows;
        pick = $urandom_range(0, 99);
        op.mode = (pick < 40) ? MODE_WRITE : (pick < 65) ? MODE_READ :
                  (pick < 95) ? MODE_COLOR : MODE_NOP;
        if (ec > 0 && er > 0 && $urandom_range(0, 99) < 85)
        begin
            op.x = 8'($urandom_range(0, ec - 1));
            op.y = 8'($urandom_range(0, er - 1));
        end
        else
        begin
            op.x = 8'($urandom_range(0, 255));
            op.y = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 9))
            0: op.value = 16'sh8000;
            1: op.value = 16'sh7fff;
            2: op.value = 16'($urandom_range(0, 15) - 8);
            3, 4: op.value = 16'($urandom_range(0, 400) - 200);
            default: op.value = 16'($urandom_range(0, 65535));
        endcase
        return op;
    endfunction

    task automatic queue_op(mode_t m, int x, int y, int v);
        grid_op_t op;
        op.mode = m;
        op.x = 8'(x);
        op.y = 8'(y);
        op.value = 16'(v);
        pending_ops.push_back(op);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WIDTH)
            cols_reg = val;
        else
            rows_reg = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || expected_pixels.size() != 0)
            @(posedge clk);
        // let the block settle before reconfiguring
        repeat (40) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        logic next_valid;
        next_valid = s_axis_tvalid;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_pixels.push_back(apply_op(pending_ops.pop_front()));
                next_valid = 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_ops.size() != 0 && !hold_ops)
                begin
                    next_valid = 1'b1;
                    s_axis_tdata <= {6'b0, pending_ops[0]};
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // receiver and checker
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        logic   next_ready;
        next_ready = m_axis_tready;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[40:0];
                next_ready = 1'b0;
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.status !== want.status || got.elev !== want.elev ||
                        got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected st=%0d e=%0d rgb=%h%h%h, got st=%0d e=%0d rgb=%h%h%h",
                                     want.status, want.elev, want.red, want.green, want.blue,
                                     got.status, got.elev, got.red, got.green, got.blue);
                    end
                end
            end
            if (!next_ready)
            begin
                if (recv_gap > 0)
                    recv_gap--;
                else
                    next_ready = 1'b1;
            end
        end
        m_axis_tready <= next_ready;
    end

    initial
    begin
        int dims [9][2];
        int cols;
        int rows;
        dims = '{'{256, 256}, '{1, 1}, '{511, 400}, '{0, 7}, '{9, 0},
                 '{256, 1}, '{1, 256}, '{16, 16}, '{40, 25}};
        for (int i = 0; i < 65536; i++)
            cells[i] = 16'sd0;
        elev_lo = 16'sd0;
        elev_hi = 16'sd0;
        cols_reg = 9'd256;
        rows_reg = 9'd256;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero span, extremes, mid value and every mode on the full grid
        queue_op(MODE_COLOR, 0, 0, 0);
        queue_op(MODE_READ, 255, 255, 0);
        queue_op(MODE_WRITE, 255, 255, 32767);
        queue_op(MODE_COLOR, 255, 255, 0);
        queue_op(MODE_COLOR, 3, 3, 0);
        queue_op(MODE_WRITE, 0, 0, -32768);
        queue_op(MODE_READ, 0, 0, 0);
        queue_op(MODE_READ, 255, 255, 0);
        queue_op(MODE_COLOR, 0, 0, 0);
        queue_op(MODE_COLOR, 255, 255, 0);
        queue_op(MODE_COLOR, 5, 5, 0);
        queue_op(MODE_WRITE, 170, 85, -1);
        queue_op(MODE_COLOR, 170, 85, 0);
        queue_op(MODE_WRITE, 85, 170, 21845);
        queue_op(MODE_COLOR, 85, 170, 12345);
        queue_op(MODE_NOP, 7, 9, -1);
        queue_op(MODE_READ, 85, 170, 0);

        for (int p = 0; p < 16; p++)
        begin
            if (p < 9)
            begin
                cols = dims[p][0];
                rows = dims[p][1];
            end
            else
            begin
                cols = $urandom_range(1, 40);
                rows = $urandom_range(1, 40);
            end
            // wait until everything is back, then hold the sender and reconfigure
            drain();
            hold_ops = 1'b1;
            write_reg(CFG_WIDTH, 9'(cols));
            write_reg(CFG_HEIGHT, 9'(rows));
            if (cols > 0 && cols <= 256 && rows > 0 && rows <= 256)
            begin
                queue_op(MODE_WRITE, cols - 1, rows - 1, 100 + p);
                queue_op(MODE_COLOR, cols - 1, rows - 1, 0);
                queue_op(MODE_READ, cols % 256, 0, 0);
                queue_op(MODE_WRITE, 0, rows % 256, 5);
            end
            for (int k = 0; k < 110; k++)
                pending_ops.push_back(random_op(cols, rows));
            hold_ops = 1'b0;
        end
        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
